// ===== sv/spi_pkg.sv =====
// ---------------------------------------------------------------------------
// spi_pkg
// Shared constants and register codes for the segment/parallelogram test.
// ---------------------------------------------------------------------------
package spi_pkg;

  localparam int FIELD_W   = 16;
  localparam int OUT_W     = 18;
  localparam int TOL_SHIFT = 20;
  localparam int CFG_IDX_W = 2;
  // quotient unit: prepare, range check, one stage per quotient bit, saturate
  localparam int DIV_LAT   = OUT_W + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER_BASE = 2'd0,
    REG_CORNER_U    = 2'd1,
    REG_CORNER_V    = 2'd2
  } reg_idx_t;

endpackage

// ===== sv/spi_seg_if.sv =====
// ---------------------------------------------------------------------------
// spi_seg_if
// Segment word channel: start and end points, signed Q8.8.
// ---------------------------------------------------------------------------
interface spi_seg_if;
  import spi_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] start_x;
  logic signed [FIELD_W-1:0] start_y;
  logic signed [FIELD_W-1:0] start_z;
  logic signed [FIELD_W-1:0] end_x;
  logic signed [FIELD_W-1:0] end_y;
  logic signed [FIELD_W-1:0] end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

// ===== sv/spi_res_if.sv =====
// ---------------------------------------------------------------------------
// spi_res_if
// Result word channel: hit, degenerate flag and saturated parameters.
// ---------------------------------------------------------------------------
interface spi_res_if;
  import spi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic                    degenerate;
  logic signed [OUT_W-1:0] param_t;
  logic signed [OUT_W-1:0] param_u;
  logic signed [OUT_W-1:0] param_v;
  modport source (output valid, hit, degenerate, param_t, param_u, param_v,
                  input ready);
  modport sink   (input valid, hit, degenerate, param_t, param_u, param_v,
                  output ready);
endinterface

// ===== sv/spi_cfg_if.sv =====
// ---------------------------------------------------------------------------
// spi_cfg_if
// Register write channel: index and write data.
// ---------------------------------------------------------------------------
interface spi_cfg_if #(parameter int DATA_W = 48);
  import spi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/segment_parallelogram_intersect_top.sv =====
// ---------------------------------------------------------------------------
// segment_parallelogram_intersect_top
// Segment against parallelogram test by Cramer's rule, fully pipelined.
// Pipeline: 6 geometry stages + spi_pkg::DIV_LAT quotient stages + 1 output
// register; one word accepted per cycle while the output is not held.
// Most of the stages are in the one-bit-per-stage quotient pipes; a held
// output word stalls the whole pipe until it is taken.
// Reset (rst, synchronous) clears every valid bit and the corner registers.
// ---------------------------------------------------------------------------
module segment_parallelogram_intersect_top #(
  parameter int COORD_WIDTH     = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  spi_seg_if.sink   seg,
  spi_res_if.source res,
  spi_cfg_if.sink   cfg
);
  import spi_pkg::*;

  localparam int C  = COORD_WIDTH;
  localparam int RW = 3 * C;
  localparam int PW = 3 * (C + 1) + 3;

  // corner registers
  logic [RW-1:0] corner_base, corner_along_u, corner_along_v;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_base    <= '0;
      corner_along_u <= '0;
      corner_along_v <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CORNER_BASE: corner_base    <= cfg.data[RW-1:0];
        REG_CORNER_U:    corner_along_u <= cfg.data[RW-1:0];
        REG_CORNER_V:    corner_along_v <= cfg.data[RW-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // The whole pipe advances together whenever the output register is free.
  logic en;
  assign en        = !res.valid || res.ready;
  assign seg.ready = en;

  // Take the low coordinate bits of each field; wider coordinates zero-fill.
  logic [31:0] raw_s [3], raw_e [3];
  logic signed [C-1:0] s [3], e [3], pb [3], pu [3], pv [3];

  always_comb begin
    raw_s[0] = {16'd0, seg.start_x};
    raw_s[1] = {16'd0, seg.start_y};
    raw_s[2] = {16'd0, seg.start_z};
    raw_e[0] = {16'd0, seg.end_x};
    raw_e[1] = {16'd0, seg.end_y};
    raw_e[2] = {16'd0, seg.end_z};
    for (int i = 0; i < 3; i++) begin
      s[i]  = $signed(raw_s[i][C-1:0]);
      e[i]  = $signed(raw_e[i][C-1:0]);
      pb[i] = $signed(corner_base[C*i +: C]);
      pu[i] = $signed(corner_along_u[C*i +: C]);
      pv[i] = $signed(corner_along_v[C*i +: C]);
    end
  end

  // geometry: determinant and numerators, determinant made positive
  logic                 g_valid, g_zero;
  logic [PW-1:0]        g_d;
  logic signed [PW-1:0] g_nt, g_nu, g_nv;

  spi_geom #(.C(C), .PW(PW)) u_geom (
    .clk(clk), .rst(rst), .en(en), .in_valid(seg.valid),
    .s(s), .e(e), .b(pb), .u(pu), .v(pv),
    .out_valid(g_valid), .det_zero(g_zero),
    .d(g_d), .nt(g_nt), .nu(g_nu), .nv(g_nv)
  );

  // three quotient pipes in lock step
  logic                    t_valid, u_valid, v_valid;
  logic                    t_in, u_in, v_in;
  logic signed [OUT_W-1:0] t_q, u_q, v_q;

  spi_div #(.PW(PW), .F(PARAM_FRAC_BITS)) u_div_t (
    .clk(clk), .rst(rst), .en(en), .in_valid(g_valid), .n(g_nt), .d(g_d),
    .out_valid(t_valid), .in_range(t_in), .q(t_q)
  );
  spi_div #(.PW(PW), .F(PARAM_FRAC_BITS)) u_div_u (
    .clk(clk), .rst(rst), .en(en), .in_valid(g_valid), .n(g_nu), .d(g_d),
    .out_valid(u_valid), .in_range(u_in), .q(u_q)
  );
  spi_div #(.PW(PW), .F(PARAM_FRAC_BITS)) u_div_v (
    .clk(clk), .rst(rst), .en(en), .in_valid(g_valid), .n(g_nv), .d(g_d),
    .out_valid(v_valid), .in_range(v_in), .q(v_q)
  );

  // carry the zero-determinant flag alongside the quotient pipes
  logic [DIV_LAT-1:0] zero_line;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_line <= {zero_line[DIV_LAT-2:0], g_zero};
    end
  end

  // output register; a zero determinant forces no hit and zero parameters
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= t_valid && u_valid && v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.degenerate <= zero_line[DIV_LAT-1];
      res.hit        <= !zero_line[DIV_LAT-1] && t_in && u_in && v_in;
      res.param_t    <= zero_line[DIV_LAT-1] ? '0 : t_q;
      res.param_u    <= zero_line[DIV_LAT-1] ? '0 : u_q;
      res.param_v    <= zero_line[DIV_LAT-1] ? '0 : v_q;
    end
  end

  // a degenerate word never reports a hit and carries zero parameters
  a_degenerate_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.degenerate |->
      !res.hit && res.param_t == '0 && res.param_u == '0 && res.param_v == '0)
    else $error("degenerate result carries a hit or nonzero parameters");

  // reset empties the pipe, so no result word follows it
  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

endmodule

// ===== sv/spi_geom.sv =====
// ---------------------------------------------------------------------------
// spi_geom
// Six-stage datapath: edge vectors, cross products, Cramer numerators and
// determinant, sign normalisation.
// ---------------------------------------------------------------------------
module spi_geom #(
  parameter int C  = 16,
  parameter int PW = 2 * (C + 1) + (C + 1) + 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [C-1:0] s   [3],
  input  logic signed [C-1:0] e   [3],
  input  logic signed [C-1:0] b   [3],
  input  logic signed [C-1:0] u   [3],
  input  logic signed [C-1:0] v   [3],
  output logic                out_valid,
  output logic                det_zero,
  output logic [PW-1:0]       d,
  output logic signed [PW-1:0] nt,
  output logic signed [PW-1:0] nu,
  output logic signed [PW-1:0] nv
);
  import spi_pkg::*;

  localparam int DW   = C + 1;
  localparam int PROD = 2 * DW;
  localparam int XW   = PROD + 1;
  localparam int DP   = DW + XW;

  logic [4:0] vld;

  logic signed [DW-1:0]   ca1 [3], cb1 [3], cc1 [3], cr1 [3];
  logic signed [DW-1:0]   ca2 [3], cr2 [3], ca3 [3], cr3 [3];
  logic signed [PROD-1:0] pbc_a [3], pbc_b [3], prc_a [3], prc_b [3];
  logic signed [PROD-1:0] pbr_a [3], pbr_b [3];
  logic signed [XW-1:0]   bxc [3], rxc [3], bxr [3];
  logic signed [DP-1:0]   m_det [3], m_nt [3], m_nu [3], m_nv [3];
  logic signed [PW-1:0]   det5, nt5, nu5, nv5;

  function automatic int nx1(input int i);
    nx1 = (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int nx2(input int i);
    nx2 = (i == 0) ? 2 : i - 1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[3:0], in_valid};
      out_valid <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // edge vectors
        ca1[i] <= DW'(s[i]) - DW'(e[i]);
        cb1[i] <= DW'(u[i]) - DW'(b[i]);
        cc1[i] <= DW'(v[i]) - DW'(b[i]);
        cr1[i] <= DW'(s[i]) - DW'(b[i]);
        // cross product terms
        pbc_a[i] <= PROD'(cb1[nx1(i)]) * PROD'(cc1[nx2(i)]);
        pbc_b[i] <= PROD'(cb1[nx2(i)]) * PROD'(cc1[nx1(i)]);
        prc_a[i] <= PROD'(cr1[nx1(i)]) * PROD'(cc1[nx2(i)]);
        prc_b[i] <= PROD'(cr1[nx2(i)]) * PROD'(cc1[nx1(i)]);
        pbr_a[i] <= PROD'(cb1[nx1(i)]) * PROD'(cr1[nx2(i)]);
        pbr_b[i] <= PROD'(cb1[nx2(i)]) * PROD'(cr1[nx1(i)]);
        ca2[i]   <= ca1[i];
        cr2[i]   <= cr1[i];
        // cross products
        bxc[i] <= XW'(pbc_a[i]) - XW'(pbc_b[i]);
        rxc[i] <= XW'(prc_a[i]) - XW'(prc_b[i]);
        bxr[i] <= XW'(pbr_a[i]) - XW'(pbr_b[i]);
        ca3[i] <= ca2[i];
        cr3[i] <= cr2[i];
        // dot product terms
        m_det[i] <= DP'(ca3[i]) * DP'(bxc[i]);
        m_nt[i]  <= DP'(cr3[i]) * DP'(bxc[i]);
        m_nu[i]  <= DP'(ca3[i]) * DP'(rxc[i]);
        m_nv[i]  <= DP'(ca3[i]) * DP'(bxr[i]);
      end
      det5 <= PW'(m_det[0]) + PW'(m_det[1]) + PW'(m_det[2]);
      nt5  <= PW'(m_nt[0])  + PW'(m_nt[1])  + PW'(m_nt[2]);
      nu5  <= PW'(m_nu[0])  + PW'(m_nu[1])  + PW'(m_nu[2]);
      nv5  <= PW'(m_nv[0])  + PW'(m_nv[1])  + PW'(m_nv[2]);
      // make the determinant positive
      det_zero <= (det5 == '0);
      d        <= det5[PW-1] ? PW'(-det5) : PW'(det5);
      nt       <= det5[PW-1] ? -nt5 : nt5;
      nu       <= det5[PW-1] ? -nu5 : nu5;
      nv       <= det5[PW-1] ? -nv5 : nv5;
    end
  end

endmodule

// ===== sv/spi_div.sv =====
// ---------------------------------------------------------------------------
// spi_div
// Pipelined rounded quotient n/d, one quotient bit a stage, with saturation
// and the unit range test on the side.
// ---------------------------------------------------------------------------
module spi_div #(
  parameter int PW = 54,
  parameter int F  = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [PW-1:0]    n,
  input  logic [PW-1:0]           d,
  output logic                    out_valid,
  output logic                    in_range,
  output logic signed [spi_pkg::OUT_W-1:0] q
);
  import spi_pkg::*;

  localparam int NB = OUT_W;
  localparam int CW = PW + F + NB + 2;
  localparam int IW = PW + TOL_SHIFT + 2;

  logic signed [IW-1:0] s_sh, d_ext, lo_sum, hi_lim;
  logic [PW-1:0]        mag;

  assign s_sh   = IW'(n) <<< TOL_SHIFT;
  assign d_ext  = $signed(IW'({1'b0, d}));
  assign lo_sum = s_sh + d_ext;
  assign hi_lim = (d_ext <<< TOL_SHIFT) + d_ext;
  assign mag    = n[PW-1] ? PW'(-n) : PW'(n);

  // prepare stage
  logic          vp, negp, inrp;
  logic [CW-1:0] nump, ddp;

  // per bit stage state, index 0 is the range check stage
  logic          vs   [NB+1];
  logic          negs [NB+1];
  logic          inrs [NB+1];
  logic          ovfs [NB+1];
  logic [CW-1:0] rems [NB+1];
  logic [CW-1:0] dds  [NB+1];
  logic [NB-1:0] qs   [NB+1];

  logic [NB-1:0] lim, mag_q;
  logic          sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
      for (int k = 0; k <= NB; k++) vs[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vp    <= in_valid;
      vs[0] <= vp;
      for (int k = 1; k <= NB; k++) vs[k] <= vs[k-1];
      out_valid <= vs[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negp <= n[PW-1];
      inrp <= !lo_sum[IW-1] && (s_sh <= hi_lim);
      nump <= (CW'(mag) << (F + 1)) + CW'(d);
      ddp  <= CW'(d) << 1;

      negs[0] <= negp;
      inrs[0] <= inrp;
      ovfs[0] <= (nump >= (ddp << NB));
      rems[0] <= nump;
      dds[0]  <= ddp;
      qs[0]   <= '0;

      for (int k = 1; k <= NB; k++) begin
        negs[k] <= negs[k-1];
        inrs[k] <= inrs[k-1];
        ovfs[k] <= ovfs[k-1];
        dds[k]  <= dds[k-1];
        if (rems[k-1] >= (dds[k-1] << (NB - k))) begin
          rems[k] <= rems[k-1] - (dds[k-1] << (NB - k));
          qs[k]   <= qs[k-1] | (NB'(1) << (NB - k));
        end else begin
          rems[k] <= rems[k-1];
          qs[k]   <= qs[k-1];
        end
      end

      in_range <= inrs[NB];
      q        <= negs[NB] ? -$signed(mag_q) : $signed(mag_q);
    end
  end

  always_comb begin
    lim   = negs[NB] ? (NB'(1) << (NB - 1)) : ((NB'(1) << (NB - 1)) - NB'(1));
    sat   = ovfs[NB] || (qs[NB] > lim);
    mag_q = sat ? lim : qs[NB];
  end

endmodule
